FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared constants and codes for the positional list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BEYOND    = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed q16.16 words with insert, delete, find and clear
// ----------------------------------------------------------------------------
// Each input word is one list operation. Insert, delete and find walk the
// stored elements one per cycle through the single read port of the list
// memory, shifting elements and tracking the minimum and maximum on the way;
// clear skips the walk. One item is worked on at a time: the next word is
// taken only once the result word of the last has been registered, and a
// new word can be accepted while the previous result word still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 kind,
  input  wire logic signed [31:0]         value,
  input  wire logic [ple_pkg::POS_W-1:0]  position,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status,
  output logic                            found,
  output logic [5:0]                      found_index,
  output logic [6:0]                      count,
  output logic                            empty_res,
  output logic signed [31:0]              min_value,
  output logic signed [31:0]              max_value
);

  import ple_pkg::*;

  state_t             state;
  logic [CNT_W-1:0]   elem_count;
  kind_t              kind_r;
  logic signed [31:0] val_r;
  logic [CMP_W-1:0]   pos_r;
  logic               op_ok;
  status_t            status_r;
  logic               found_r;
  logic [ADDR_W-1:0]  fidx_r;
  logic               have;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic [ADDR_W-1:0]  rd_idx;
  logic [CNT_W-1:0]   rd_left;
  logic               d_vld;
  logic [ADDR_W-1:0]  d_idx;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic [DATA_W-1:0]  rd_data;
  logic signed [31:0] rd_val;

  logic               ins_ok;
  logic               del_ok;
  logic               scan_done;
  logic               excl;
  logic               fin_fire;
  logic [CMP_W-1:0]   pos_in;
  logic [CMP_W-1:0]   cnt_c;
  logic [CMP_W-1:0]   d_idx_c;
  logic [CNT_W-1:0]   last_idx;

  ple_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_idx),
    .rd_data(rd_data)
  );

  assign in_ready  = (state == ST_IDLE);
  assign rd_val    = $signed(rd_data);
  assign ins_ok    = (kind_r == KIND_INSERT) && op_ok;
  assign del_ok    = (kind_r == KIND_DELETE) && op_ok;
  assign scan_done = (rd_left == '0) && !d_vld;
  assign fin_fire  = (state == ST_FINISH) && (!out_valid || out_ready);
  assign pos_in    = CMP_W'(position);
  assign cnt_c     = CMP_W'(elem_count);
  assign d_idx_c   = CMP_W'(d_idx);
  assign excl      = del_ok && (d_idx_c == pos_r);
  assign last_idx  = elem_count - CNT_W'(1);

  // shift writes during the walk, new element written after it
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = d_idx;
    wr_data = rd_data;
    if (state == ST_SCAN) begin
      if (d_vld) begin
        if (ins_ok && d_idx_c >= pos_r) begin
          wr_en   = 1'b1;
          wr_addr = d_idx + ADDR_W'(1);
        end else if (del_ok && d_idx_c > pos_r) begin
          wr_en   = 1'b1;
          wr_addr = d_idx - ADDR_W'(1);
        end
      end else if (scan_done && ins_ok) begin
        wr_en   = 1'b1;
        wr_addr = pos_r[ADDR_W-1:0];
        wr_data = val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      elem_count <= '0;
      out_valid  <= 1'b0;
      d_vld      <= 1'b0;
      rd_left    <= '0;
    end else begin
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r  <= kind_t'(kind);
            val_r   <= value;
            found_r <= 1'b0;
            fidx_r  <= '0;
            d_vld   <= 1'b0;
            lo      <= value;
            hi      <= value;
            pos_r   <= (kind_t'(kind) == KIND_INSERT && pos_in > cnt_c) ? cnt_c : pos_in;
            case (kind_t'(kind))
              KIND_INSERT: begin
                state   <= ST_SCAN;
                rd_idx  <= last_idx[ADDR_W-1:0];
                rd_left <= elem_count;
                if (elem_count >= CNT_W'(CAPACITY)) begin
                  status_r <= STAT_FULL;
                  op_ok    <= 1'b0;
                  have     <= 1'b0;
                end else begin
                  status_r <= STAT_OK;
                  op_ok    <= 1'b1;
                  have     <= 1'b1;
                end
              end
              KIND_DELETE: begin
                state   <= ST_SCAN;
                rd_idx  <= '0;
                rd_left <= elem_count;
                have    <= 1'b0;
                if (pos_in >= cnt_c) begin
                  status_r <= STAT_BEYOND;
                  op_ok    <= 1'b0;
                end else begin
                  status_r <= STAT_OK;
                  op_ok    <= 1'b1;
                end
              end
              KIND_FIND: begin
                state    <= ST_SCAN;
                rd_idx   <= '0;
                rd_left  <= elem_count;
                status_r <= STAT_NOT_FOUND;
                op_ok    <= 1'b0;
                have     <= 1'b0;
              end
              default: begin
                state      <= ST_FINISH;
                rd_idx     <= '0;
                rd_left    <= '0;
                status_r   <= STAT_OK;
                op_ok      <= 1'b0;
                have       <= 1'b0;
                elem_count <= '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_left != '0) begin
            d_vld   <= 1'b1;
            d_idx   <= rd_idx;
            rd_left <= rd_left - CNT_W'(1);
            if (kind_r == KIND_INSERT) begin
              rd_idx <= rd_idx - ADDR_W'(1);
            end else begin
              rd_idx <= rd_idx + ADDR_W'(1);
            end
          end else begin
            d_vld <= 1'b0;
          end
          if (d_vld) begin
            if (!excl) begin
              have <= 1'b1;
              if (!have || rd_val < lo) begin
                lo <= rd_val;
              end
              if (!have || rd_val > hi) begin
                hi <= rd_val;
              end
            end
            if (kind_r == KIND_FIND && !found_r && rd_val == val_r) begin
              found_r  <= 1'b1;
              fidx_r   <= d_idx;
              status_r <= STAT_OK;
            end
          end
          if (scan_done) begin
            if (ins_ok) begin
              elem_count <= elem_count + CNT_W'(1);
            end else if (del_ok) begin
              elem_count <= elem_count - CNT_W'(1);
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_fire) begin
            status      <= status_r;
            found       <= found_r;
            found_index <= 6'(fidx_r);
            count       <= 7'(elem_count);
            empty_res   <= (elem_count == '0);
            min_value   <= have ? lo : 32'sd0;
            max_value   <= have ? hi : 32'sd0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_wr_in_list: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) <= elem_count))
    else $error("list write outside stored range");

  a_empty_minmax: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> (min_value == 32'sd0) && (max_value == 32'sd0))
    else $error("empty list reports nonzero min or max");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (status == STAT_OK))
    else $error("found flag with failing status");

endmodule

`default_nettype wire

FILE: tb/sv/tb_positional_list_engine.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// self-checking testbench for the positional list engine
// ----------------------------------------------------------------------------
// Keeps a shadow copy of the list and predicts the result word for every
// accepted operation word. Directed tests cover the empty list, the list
// extremes, appends past the end, out-of-range deletes and the full list.
// Random phases then mix operations with different sender and receiver
// idling. A pressure test holds the result side off while operations keep
// coming. Result words are compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    status_t            status;
    logic               found;
    logic [5:0]         found_index;
    logic [6:0]         count;
    logic               empty_res;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              kind;
  logic signed [31:0]      value;
  logic [POS_W-1:0]        position;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic                    found;
  logic [5:0]              found_index;
  logic [6:0]              count;
  logic                    empty_res;
  logic signed [31:0]      min_value;
  logic signed [31:0]      max_value;

  logic signed [31:0]      shadow_list [CAPACITY];
  int                      shadow_count;
  list_result_t            list_results_due [$];
  int                      mismatch_count = 0;
  int                      words_checked = 0;
  int                      idle_pct;
  int                      stall_pct;
  int                      hold_request = 0;
  int                      hold_taken = 0;
  int                      hold_left = 0;
  int                      quiet_cycles = 0;

  positional_list_engine dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .found_index (found_index),
    .count       (count),
    .empty_res   (empty_res),
    .min_value   (min_value),
    .max_value   (max_value)
  );

  always #2 clk = ~clk;

  function automatic list_result_t apply_list_op(kind_t op, logic signed [31:0] v,
                                                 logic [6:0] p);
    list_result_t r;
    int at;
    int i;
    int hit;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    r.status = STAT_OK;
    r.found = 1'b0;
    hit = 0;
    lo = '0;
    hi = '0;
    case (op)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          at = (int'(p) > shadow_count) ? shadow_count : int'(p);
          for (i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[at] = v;
          shadow_count++;
        end
      end
      KIND_DELETE: begin
        if (int'(p) >= shadow_count) begin
          r.status = STAT_BEYOND;
        end else begin
          for (i = int'(p); i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
        end
      end
      KIND_FIND: begin
        r.status = STAT_NOT_FOUND;
        for (i = 0; i < shadow_count && !r.found; i++) begin
          if (shadow_list[i] == v) begin
            r.status = STAT_OK;
            r.found = 1'b1;
            hit = i;
          end
        end
      end
      default: shadow_count = 0;
    endcase
    if (shadow_count > 0) begin
      lo = shadow_list[0];
      hi = shadow_list[0];
      for (i = 1; i < shadow_count; i++) begin
        if (shadow_list[i] < lo) lo = shadow_list[i];
        if (shadow_list[i] > hi) hi = shadow_list[i];
      end
    end
    r.found_index = hit[5:0];
    r.count = shadow_count[6:0];
    r.empty_res = (shadow_count == 0);
    r.min_value = lo;
    r.max_value = hi;
    return r;
  endfunction

  // mix of wide random, small clustered, extreme and already stored values
  function automatic logic [31:0] pick_value(bit prefer_stored);
    int r;
    r = $urandom_range(9);
    if ((prefer_stored || r >= 7) && shadow_count > 0 && $urandom_range(3) != 0)
      return shadow_list[$urandom_range(shadow_count - 1)];
    case (r)
      4, 5: return (32'($urandom_range(7)) - 32'd3) << 16;
      6: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(kind_t op, logic [31:0] v, logic [6:0] p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    value <= v;
    position <= p;
    do @(posedge clk); while (!in_ready);
    list_results_due.push_back(apply_list_op(op, v, p));
    @(negedge clk);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on word %0d, %s: got %0d, expected %0d",
             words_checked, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_random_word(bit grow);
    int r;
    kind_t op;
    logic [6:0] p;
    r = $urandom_range(99);
    if (grow)
      op = (r < 60) ? KIND_INSERT : (r < 78) ? KIND_DELETE : (r < 98) ? KIND_FIND : KIND_CLEAR;
    else
      op = (r < 25) ? KIND_INSERT : (r < 70) ? KIND_DELETE : (r < 98) ? KIND_FIND : KIND_CLEAR;
    p = $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(shadow_count));
    send_word(op, pick_value(op == KIND_FIND), p);
  endtask

  task automatic test_directed();
    send_word(KIND_CLEAR, 32'h0, 7'd0);
    send_word(KIND_DELETE, 32'h0, 7'd0);
    send_word(KIND_FIND, 32'h0, 7'd0);
    send_word(KIND_INSERT, 32'h8000_0000, 7'd0);
    send_word(KIND_INSERT, 32'h7fff_ffff, 7'd127);
    send_word(KIND_INSERT, 32'h0001_0000, 7'd1);
    send_word(KIND_INSERT, 32'h0001_0000, 7'd0);
    send_word(KIND_INSERT, 32'hffff_ffff, 7'd64);
    send_word(KIND_FIND, 32'h0001_0000, 7'd0);
    send_word(KIND_FIND, 32'h7fff_ffff, 7'd127);
    send_word(KIND_FIND, 32'h1234_5678, 7'd0);
    send_word(KIND_DELETE, 32'h0, 7'd5);
    send_word(KIND_DELETE, 32'hffff_ffff, 7'd127);
    send_word(KIND_DELETE, 32'h0, 7'd0);
    send_word(KIND_DELETE, 32'h0, 7'd3);
    send_word(KIND_FIND, 32'h8000_0000, 7'd0);
    send_word(KIND_CLEAR, 32'hdead_beef, 7'd100);
    send_word(KIND_FIND, 32'h0001_0000, 7'd0);
    send_word(KIND_INSERT, 32'h0, 7'd127);
    send_word(KIND_DELETE, 32'h0, 7'd0);
  endtask

  task automatic test_full_list();
    send_word(KIND_CLEAR, $urandom, 7'($urandom_range(127)));
    while (shadow_count < CAPACITY)
      send_word(KIND_INSERT, pick_value(1'b0), 7'($urandom_range(127)));
    send_word(KIND_INSERT, $urandom, 7'($urandom_range(127)));
    send_word(KIND_INSERT, 32'h7fff_ffff, 7'd0);
    send_word(KIND_FIND, shadow_list[CAPACITY - 1], 7'd0);
    send_word(KIND_FIND, 32'h1357_9bdf, 7'd0);
    send_word(KIND_DELETE, 32'h0, 7'd64);
    send_word(KIND_DELETE, 32'h0, 7'd63);
    send_word(KIND_INSERT, 32'h8000_0000, 7'd127);
    send_word(KIND_INSERT, $urandom, 7'd10);
  endtask

  task automatic test_random(int n, int sender_idle, int receiver_stall);
    int i;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (i = 0; i < n; i++) send_random_word(((i / 40) % 2) == 0);
  endtask

  task automatic test_backpressure();
    int i;
    idle_pct = 0;
    stall_pct = 0;
    hold_request++;
    for (i = 0; i < 30; i++) send_random_word(1'b1);
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_request != hold_taken) begin
      hold_taken = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (list_results_due.size() == 0) begin
        report_mismatch("unexpected word, status", status, 0);
      end else begin
        want = list_results_due.pop_front();
        if (status != want.status) report_mismatch("status", status, want.status);
        if (found != want.found) report_mismatch("found", found, want.found);
        if (found_index != want.found_index)
          report_mismatch("found_index", found_index, want.found_index);
        if (count != want.count) report_mismatch("count", count, want.count);
        if (empty_res != want.empty_res) report_mismatch("empty_res", empty_res, want.empty_res);
        if (min_value != want.min_value) report_mismatch("min_value", min_value, want.min_value);
        if (max_value != want.max_value) report_mismatch("max_value", max_value, want.max_value);
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[positional_list_engine] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    value = '0;
    position = '0;
    shadow_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_full_list();
    test_random(100, 0, 0);
    test_random(100, 54, 0);
    test_random(100, 0, 54);
    test_random(100, 13, 13);
    test_backpressure();
    test_random(40, 13, 13);

    in_valid <= 1'b0;
    while (list_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[positional_list_engine] OK");
    end else begin
      $display("[positional_list_engine] ERROR");
    end
    $finish;
  end

endmodule
